FILE: sv/dmj_pkg.sv
// Shared types, constants and month tables for the day-number to calendar-date block.
package dmj_pkg;

    // Fixed point of the seconds fields.
    localparam int FRAC_BITS = 20;
    localparam int DAY_W     = 31;
    localparam int SEC_W     = 52;
    localparam int SINT_W    = SEC_W - FRAC_BITS;
    localparam int YEAR_W    = 23;

    // Calendar mode register codes; the fourth code behaves as always Julian.
    localparam logic [1:0] MODE_GREGORIAN = 2'd0;
    localparam logic [1:0] MODE_AUTO      = 2'd1;
    localparam logic [1:0] MODE_JULIAN    = 2'd2;

    // Day-number offsets to the start of year 0 in each calendar, and the reform day.
    localparam logic signed [31:0] EPOCH_JULIAN    = 32'sd678943;
    localparam logic signed [31:0] EPOCH_GREGORIAN = 32'sd678941;
    localparam logic signed [31:0] REFORM_DAY      = -32'sd100840;

    // One minute in fixed point, the exclusive bound of the seconds output.
    localparam logic [25:0] MINUTE_LEN = 26'(60) << FRAC_BITS;

    // Time of day as it travels down the pipeline.
    typedef struct packed {
        logic [4:0]           hour;
        logic [5:0]           minute;
        logic [5:0]           sec;
        logic [FRAC_BITS-1:0] frac;
    } t_time;

    // Date state carried alongside the inner century divider.
    typedef struct packed {
        logic        julian;
        logic [10:0] rem_julian;
        logic [10:0] rem_century;
        logic        short_century;
        logic [23:0] year_base;
    } t_mid;

    // First day of year of each month, common or leap year.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] month);
        logic [8:0] start;
        begin
            case (month)
                4'd0:    start = 9'd0;
                4'd1:    start = 9'd31;
                4'd2:    start = leap ? 9'd60  : 9'd59;
                4'd3:    start = leap ? 9'd91  : 9'd90;
                4'd4:    start = leap ? 9'd121 : 9'd120;
                4'd5:    start = leap ? 9'd152 : 9'd151;
                4'd6:    start = leap ? 9'd182 : 9'd181;
                4'd7:    start = leap ? 9'd213 : 9'd212;
                4'd8:    start = leap ? 9'd244 : 9'd243;
                4'd9:    start = leap ? 9'd274 : 9'd273;
                4'd10:   start = leap ? 9'd305 : 9'd304;
                4'd11:   start = leap ? 9'd335 : 9'd334;
                default: start = 9'd0;
            endcase
            return start;
        end
    endfunction

endpackage

FILE: sv/dmj_fdiv.sv
// Three-stage floor division of a signed value by a constant, with remainder.
module dmj_fdiv #(
    parameter int W  = 32,
    parameter int D  = 1461,
    parameter int RW = 11
) (
    input  logic                i_clk,
    input  logic [2:0]          i_en,
    input  logic signed [W-1:0] i_x,
    output logic signed [W-1:0] o_q,
    output logic [RW-1:0]       o_r
);

    localparam int K = W - 1;
    localparam longint unsigned MFULL = (64'd1 << K) / D;
    localparam int MW = $clog2(MFULL + 1);
    localparam int PW = K + MW;
    localparam logic [MW-1:0] MK = MW'(MFULL);
    localparam logic [K-1:0]  DK = K'(D);
    localparam logic [RW-1:0] DM1 = RW'(D - 1);

    logic [K-1:0]  u;
    logic [PW-1:0] prod;
    logic [MW-1:0] r_qa, r_qb;
    logic [K-1:0]  r_ua, r_ub, r_pb;
    logic          r_na, r_nb;
    logic [K-1:0]  diff, qk;
    logic          ge;
    logic [RW-1:0] rem;

    // A negative input is folded to its one's complement so the divide is unsigned.
    assign u    = i_x[W-1] ? ~i_x[K-1:0] : i_x[K-1:0];
    assign prod = PW'(u) * PW'(MK);

    // Estimate, which is the true quotient or one below it.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_qa <= prod[PW-1:K];
            r_ua <= u;
            r_na <= i_x[W-1];
        end
    end

    // Multiply back to find the remainder of the estimate.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_pb <= K'(r_qa) * DK;
            r_qb <= r_qa;
            r_ub <= r_ua;
            r_nb <= r_na;
        end
    end

    // Correct by one step and restore the sign for floor semantics.
    assign diff = r_ub - r_pb;
    assign ge   = (diff >= DK);
    assign qk   = K'(r_qb) + K'(ge);
    assign rem  = ge ? RW'(diff - DK) : RW'(diff);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_q <= r_nb ? $signed(~{1'b0, qk}) : $signed({1'b0, qk});
            o_r <= r_nb ? DM1 - rem : rem;
        end
    end

endmodule

FILE: sv/day_number_to_calendar_date.sv
// Top level: modified Julian day plus seconds offset to calendar date and time of day.
//
//   channel  | direction | handshake            | beat
//   ---------+-----------+----------------------+------------------------------------
//   cfg      | in        | i_cfg_valid/ready    | calendar mode, 2 bits
//   input    | in        | i_valid / o_stall    | day number, seconds offset
//   result   | out       | o_valid / i_stall    | year, month, day, hour, minute, sec
//
// Fourteen register stages: one beat enters per cycle while o_stall is low.
// The three chained constant dividers (day length, 400/4-year cycle, 4-year cycle) set depth.
// Reset is synchronous and clears the valid bits; the calendar mode resets to automatic.
// A stall holds only the stages that are full, so bubbles close up and nothing is lost.
module day_number_to_calendar_date (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_calendar_mode,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [30:0]  i_day_number,
    input  logic signed [51:0]  i_seconds_offset,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [22:0]  o_year_out,
    output logic [3:0]          o_month_out,
    output logic [4:0]          o_day_of_month,
    output logic [4:0]          o_hour_out,
    output logic [5:0]          o_minute_out,
    output logic [25:0]         o_second_out
);

    localparam int N = 14;
    localparam int FB = dmj_pkg::FRAC_BITS;
    localparam logic [17:0] HOUR_RECIP = 18'd149131;
    localparam logic [26:0] MIN_RECIP  = 27'd17477;

    logic [N:1] r_v;
    logic [N:1] en;
    logic [1:0] r_mode;

    // Configuration register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= dmj_pkg::MODE_AUTO;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_calendar_mode;
        end
    end

    // A stage loads when it or some stage after it has room.
    for (genvar g = 1; g <= N; g++) begin : g_en
        assign en[g] = !i_stall || !(&r_v[N:g]);
    end

    assign o_stall = !en[1];
    assign o_valid = r_v[N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int i = 2; i <= N; i++) begin
                if (en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // Stages 1 to 3: whole seconds split into days and seconds of day.
    logic signed [dmj_pkg::SINT_W-1:0] sint;
    logic signed [31:0]                q_day;
    logic [16:0]                       r_sec;
    logic signed [30:0]                r_day [1:3];
    logic [FB-1:0]                     r_frac [1:3];

    assign sint = $signed(i_seconds_offset[51:FB]);

    dmj_fdiv #(.W(32), .D(86400), .RW(17)) u_div_day (
        .i_clk (i_clk),
        .i_en  (en[3:1]),
        .i_x   (sint),
        .o_q   (q_day),
        .o_r   (r_sec)
    );

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_day[1]  <= i_day_number;
            r_frac[1] <= i_seconds_offset[FB-1:0];
        end
        for (int i = 2; i <= 3; i++) begin
            if (en[i]) begin
                r_day[i]  <= r_day[i-1];
                r_frac[i] <= r_frac[i-1];
            end
        end
    end

    // Stage 4: final day, calendar choice and hour.
    logic signed [31:0] j_day, d_day;
    logic               julian;
    logic [34:0]        hprod;
    logic signed [31:0] r_d4;
    logic               r_jul [4:7];
    logic [4:0]         r_hr4, r_hr5, r_hr6;
    logic [16:0]        r_rs4;
    logic [FB-1:0]      r_fr4, r_fr5, r_fr6;

    assign j_day = {r_day[3][30], r_day[3]} + q_day;

    always_comb begin
        unique case (r_mode)
            dmj_pkg::MODE_GREGORIAN: julian = 1'b0;
            dmj_pkg::MODE_AUTO:      julian = (j_day < dmj_pkg::REFORM_DAY);
            default:                 julian = 1'b1;
        endcase
    end

    assign d_day = j_day + (julian ? dmj_pkg::EPOCH_JULIAN : dmj_pkg::EPOCH_GREGORIAN);
    assign hprod = 35'(r_sec) * 35'(HOUR_RECIP);

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_d4     <= d_day;
            r_jul[4] <= julian;
            r_hr4    <= hprod[33:29];
            r_rs4    <= r_sec;
            r_fr4    <= r_frac[3];
        end
        for (int i = 5; i <= 7; i++) begin
            if (en[i]) begin
                r_jul[i] <= r_jul[i-1];
            end
        end
    end

    // Stages 5 to 7: minute and second of the time of day.
    logic [16:0] rh_full;
    logic [11:0] r_rh5, r_rh6;
    logic [26:0] mprod;
    logic [5:0]  r_mn6;
    logic [11:0] sec_full;
    dmj_pkg::t_time r_tm [7:N];

    assign rh_full  = r_rs4 - 17'(r_hr4) * 17'd3600;
    assign mprod    = 27'(r_rh5) * MIN_RECIP;
    assign sec_full = r_rh6 - 12'(r_mn6) * 12'd60;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_rh5 <= rh_full[11:0];
            r_hr5 <= r_hr4;
            r_fr5 <= r_fr4;
        end
        if (en[6]) begin
            r_mn6 <= mprod[25:20];
            r_rh6 <= r_rh5;
            r_hr6 <= r_hr5;
            r_fr6 <= r_fr5;
        end
        if (en[7]) begin
            r_tm[7].hour   <= r_hr6;
            r_tm[7].minute <= r_mn6;
            r_tm[7].sec    <= sec_full[5:0];
            r_tm[7].frac   <= r_fr6;
        end
        for (int i = 8; i <= N; i++) begin
            if (en[i]) begin
                r_tm[i] <= r_tm[i-1];
            end
        end
    end

    // Stages 5 to 7: four-year Julian cycles and 400-year Gregorian cycles.
    logic signed [31:0] q_j, q_g;
    logic [10:0]        r_j;
    logic [17:0]        r_g;

    dmj_fdiv #(.W(32), .D(1461), .RW(11)) u_div_julian (
        .i_clk (i_clk),
        .i_en  (en[7:5]),
        .i_x   (r_d4),
        .o_q   (q_j),
        .o_r   (r_j)
    );

    dmj_fdiv #(.W(32), .D(146097), .RW(18)) u_div_greg (
        .i_clk (i_clk),
        .i_en  (en[7:5]),
        .i_x   (r_d4),
        .o_q   (q_g),
        .o_r   (r_g)
    );

    // Stage 8: century within the 400-year cycle.
    logic [1:0]     cent;
    logic [17:0]    cent_sub;
    logic [17:0]    rc_full;
    logic [15:0]    rc;
    logic           short_c;
    logic [15:0]    vb;
    logic [23:0]    yb;
    logic signed [16:0] r_vb8;
    dmj_pkg::t_mid  r_mid [8:11];

    assign cent = 2'(r_g >= 18'd36525) + 2'(r_g >= 18'd73049) + 2'(r_g >= 18'd109573);

    always_comb begin
        case (cent)
            2'd0:    cent_sub = 18'd0;
            2'd1:    cent_sub = 18'd36525;
            2'd2:    cent_sub = 18'd73049;
            default: cent_sub = 18'd109573;
        endcase
    end

    assign rc_full = r_g - cent_sub;
    assign rc      = rc_full[15:0];
    assign short_c = (cent != 2'd0) && (rc < 16'd1460);
    // Past the first century the four-year blocks are shifted by one day.
    assign vb      = (cent != 2'd0) ? rc + 16'd1 : rc;
    assign yb      = r_jul[7] ? (q_j[23:0] << 2)
                              : (q_g[23:0] * 24'd400 + 24'(cent) * 24'd100);

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_vb8                  <= $signed({1'b0, vb});
            r_mid[8].julian        <= r_jul[7];
            r_mid[8].rem_julian    <= r_j;
            r_mid[8].rem_century   <= rc[10:0];
            r_mid[8].short_century <= short_c;
            r_mid[8].year_base     <= yb;
        end
        for (int i = 9; i <= 11; i++) begin
            if (en[i]) begin
                r_mid[i] <= r_mid[i-1];
            end
        end
    end

    // Stages 9 to 11: four-year blocks within the Gregorian century.
    logic signed [16:0] q_b;
    logic [10:0]        r_b;

    dmj_fdiv #(.W(17), .D(1461), .RW(11)) u_div_block (
        .i_clk (i_clk),
        .i_en  (en[11:9]),
        .i_x   (r_vb8),
        .o_q   (q_b),
        .o_r   (r_b)
    );

    // Stage 12: day within the four-year block and year base.
    logic [10:0] rb_sel;
    logic [23:0] yb_sel;
    logic [10:0] r_rb12;
    logic [23:0] r_yb12;

    always_comb begin
        if (r_mid[11].julian) begin
            rb_sel = r_mid[11].rem_julian;
            yb_sel = r_mid[11].year_base;
        end else begin
            // A century that starts with a common year counts from one year early.
            rb_sel = r_mid[11].short_century ? r_mid[11].rem_century + 11'd366 : r_b;
            yb_sel = r_mid[11].year_base + (24'(q_b[15:0]) << 2)
                     - 24'(r_mid[11].short_century);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[12]) begin
            r_rb12 <= rb_sel;
            r_yb12 <= yb_sel;
        end
    end

    // Stage 13: year within the block and day of year.
    logic [2:0]  yblk;
    logic [10:0] ystart;
    logic [10:0] doy_full;
    logic [23:0] r_yr13;
    logic [8:0]  r_doy13;
    logic        r_leap13;

    assign yblk = 3'(r_rb12 >= 11'd366) + 3'(r_rb12 >= 11'd731)
                + 3'(r_rb12 >= 11'd1096) + 3'(r_rb12 >= 11'd1461);

    always_comb begin
        case (yblk)
            3'd0:    ystart = 11'd0;
            3'd1:    ystart = 11'd366;
            3'd2:    ystart = 11'd731;
            3'd3:    ystart = 11'd1096;
            default: ystart = 11'd1461;
        endcase
    end

    assign doy_full = r_rb12 - ystart;

    always_ff @(posedge i_clk) begin
        if (en[13]) begin
            r_yr13   <= r_yb12 + 24'(yblk);
            r_doy13  <= doy_full[8:0];
            r_leap13 <= (yblk == 3'd0);
        end
    end

    // Stage 14: month and day of month, into the output register.
    logic [11:1] past;
    logic [3:0]  month;
    logic [8:0]  dom_full;
    logic [22:0] r_yr14;
    logic [3:0]  r_mon14;
    logic [4:0]  r_dom14;

    always_comb begin
        for (int k = 1; k < 12; k++) begin
            past[k] = (r_doy13 >= dmj_pkg::month_start(r_leap13, 4'(k)));
        end
    end

    assign month    = 4'($countones(past));
    assign dom_full = r_doy13 - dmj_pkg::month_start(r_leap13, month) + 9'd1;

    always_ff @(posedge i_clk) begin
        if (en[14]) begin
            r_yr14  <= r_yr13[22:0];
            r_mon14 <= month;
            r_dom14 <= dom_full[4:0];
        end
    end

    assign o_year_out     = $signed(r_yr14);
    assign o_month_out    = r_mon14;
    assign o_day_of_month = r_dom14;
    assign o_hour_out     = r_tm[N].hour;
    assign o_minute_out   = r_tm[N].minute;
    assign o_second_out   = {r_tm[N].sec, r_tm[N].frac};

endmodule

FILE: sv/dmj_check.sv
// Port-level checker for the calendar-date block, bound to the top level.
module dmj_check (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [22:0] o_year_out,
    input logic [3:0]         o_month_out,
    input logic [4:0]         o_day_of_month,
    input logic [4:0]         o_hour_out,
    input logic [5:0]         o_minute_out,
    input logic [25:0]        o_second_out
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat valid right after reset");

    // A stalled result beat stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result beat withdrawn");

    // A stalled result beat keeps its date.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_year_out) && $stable(o_month_out)
                                  && $stable(o_day_of_month)))
        else $error("stalled result beat changed");

    // Month, hour, minute and second lie within range, and the day of month is at least one.
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_out <= 4'd11 && o_day_of_month >= 5'd1
                     && o_hour_out <= 5'd23 && o_minute_out <= 6'd59
                     && o_second_out < dmj_pkg::MINUTE_LEN))
        else $error("result field out of range");

    // February never runs past its leap day.
    a_february: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_month_out == 4'd1) |-> o_day_of_month <= 5'd29)
        else $error("february day out of range");

endmodule

bind day_number_to_calendar_date dmj_check u_dmj_check (.*);

FILE: tb/sv/tb_top.sv
// Testbench for the calendar-date block: directed and random beats checked by a predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam longint DAY_LEN  = longint'(86400) << dmj_pkg::FRAC_BITS;
    localparam longint HOUR_LEN = longint'(3600) << dmj_pkg::FRAC_BITS;
    localparam longint MIN_LEN  = longint'(60) << dmj_pkg::FRAC_BITS;
    localparam longint DAY_MAX  = 64'sd1073741823;
    localparam longint DAY_MIN  = -64'sd1073741824;
    localparam longint SEC_MAX  = 64'sd2251799813685247;
    localparam longint SEC_MIN  = -64'sd2251799813685248;
    localparam int     LATENCY  = 14;
    localparam longint LIMIT    = 400000;

    // One calendar date with time of day.
    typedef struct packed {
        logic signed [22:0] year;
        logic [3:0]         month;
        logic [4:0]         mday;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [25:0]        sec;
    } t_date;

    // Directed stimulus row; the date is checked only where has_date is set.
    typedef struct {
        longint day;
        longint secs;
        bit     has_date;
        t_date  date;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_calendar_mode;
    logic               i_valid;
    logic               o_stall;
    logic signed [30:0] i_day_number;
    logic signed [51:0] i_seconds_offset;
    logic               o_valid;
    logic               i_stall;
    logic signed [22:0] o_year_out;
    logic [3:0]         o_month_out;
    logic [4:0]         o_day_of_month;
    logic [4:0]         o_hour_out;
    logic [5:0]         o_minute_out;
    logic [25:0]        o_second_out;

    day_number_to_calendar_date DUT (.*);

    t_date  pending_dates[$];
    t_date  typed_date;
    bit     typed_valid;
    logic [1:0] mode_copy;
    int     errors;
    int     beats_in;
    int     beats_out;
    longint cycles;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     long_hold;
    int     hold_count;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    // Splits a day count within a leap-first four-year block.
    function automatic void block_split(longint rb, output longint yr, output longint doy,
                                        output bit leap);
        if (rb < 366) begin
            yr = 0; doy = rb; leap = 1;
        end else begin
            yr = 1 + (rb - 366) / 365; doy = (rb - 366) % 365; leap = 0;
        end
    endfunction

    // Predicts the calendar date of one beat under the given mode.
    function automatic t_date calendar_of(logic [1:0] mode, longint day, longint secs);
        longint extra, rem, j, d, q, r, c, rc, b, y, rb, yr, doy, hr, mn;
        bit     leap, jul;
        int     m;
        t_date  res;
        extra = fdiv(secs, DAY_LEN);
        rem = secs - extra * DAY_LEN;
        j = day + extra;
        if (mode == dmj_pkg::MODE_GREGORIAN) jul = 0;
        else if (mode == dmj_pkg::MODE_AUTO) jul = (j < dmj_pkg::REFORM_DAY);
        else jul = 1;
        if (jul) begin
            d = j + dmj_pkg::EPOCH_JULIAN;
            q = fdiv(d, 1461);
            block_split(d - q * 1461, y, doy, leap);
            yr = 4 * q + y;
        end else begin
            d = j + dmj_pkg::EPOCH_GREGORIAN;
            q = fdiv(d, 146097);
            r = d - q * 146097;
            if (r < 36525) begin
                c = 0; rc = r;
            end else begin
                c = 1 + (r - 36525) / 36524; rc = (r - 36525) % 36524;
            end
            if (c > 0 && rc < 1460) begin
                b = 0; y = rc / 365; doy = rc % 365; leap = 0;
            end else begin
                if (c > 0) begin
                    b = 1 + (rc - 1460) / 1461; rb = (rc - 1460) % 1461;
                end else begin
                    b = rc / 1461; rb = rc % 1461;
                end
                block_split(rb, y, doy, leap);
            end
            yr = 400 * q + 100 * c + 4 * b + y;
        end
        m = 11;
        while (m > 0 && doy < longint'(dmj_pkg::month_start(leap, 4'(m)))) m--;
        hr = rem / HOUR_LEN;
        rem -= hr * HOUR_LEN;
        mn = rem / MIN_LEN;
        rem -= mn * MIN_LEN;
        res.year   = 23'(yr);
        res.month  = 4'(m);
        res.mday   = 5'(doy - longint'(dmj_pkg::month_start(leap, 4'(m))) + 1);
        res.hour   = 5'(hr);
        res.minute = 6'(mn);
        res.sec    = 26'(rem);
        return res;
    endfunction

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stall: random, with a long hold-off when requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_count <= 0;
        end else if (long_hold) begin
            hold_count <= hold_count + 1;
            i_stall <= (hold_count < 200);
        end else begin
            hold_count <= 0;
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checking against the oldest expected date.
    always @(posedge i_clk) begin
        t_date exp_d;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_out++;
            if (pending_dates.size() == 0) begin
                $error("result beat with no expected date");
                errors++;
            end else begin
                exp_d = pending_dates.pop_front();
                if (o_year_out !== exp_d.year) begin
                    $error("year_out exp %0d got %0d", exp_d.year, o_year_out); errors++;
                end
                if (o_month_out !== exp_d.month) begin
                    $error("month_out exp %0d got %0d", exp_d.month, o_month_out); errors++;
                end
                if (o_day_of_month !== exp_d.mday) begin
                    $error("day_of_month exp %0d got %0d", exp_d.mday, o_day_of_month);
                    errors++;
                end
                if (o_hour_out !== exp_d.hour) begin
                    $error("hour_out exp %0d got %0d", exp_d.hour, o_hour_out); errors++;
                end
                if (o_minute_out !== exp_d.minute) begin
                    $error("minute_out exp %0d got %0d", exp_d.minute, o_minute_out); errors++;
                end
                if (o_second_out !== exp_d.sec) begin
                    $error("second_out exp %0d got %0d", exp_d.sec, o_second_out); errors++;
                end
            end
        end
    end

    // Sends one beat, holding it while stalled; queues its expected date.
    // Valid stays high after acceptance so the next beat can follow at once.
    task automatic send_beat(longint day, longint secs, bit has_date, t_date date);
        t_date pred;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_day_number <= 31'(day);
        i_seconds_offset <= 52'(secs);
        pred = calendar_of(mode_copy, day, secs);
        if (has_date && pred !== date) begin
            $error("typed date differs from predictor for day %0d", day);
            errors++;
        end
        pending_dates.push_back(has_date ? date : pred);
        do @(posedge i_clk); while (o_stall);
        beats_in++;
    endtask

    // Drops valid and waits until every expected result has come.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Writes the mode register while the block is idle.
    task automatic write_mode(logic [1:0] mode);
        i_cfg_valid <= 1'b1;
        i_cfg_calendar_mode <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_copy = mode;
    endtask

    task automatic random_beats(int count);
        longint day, secs;
        int     sel;
        repeat (count) begin
            sel = $urandom_range(9);
            case (sel)
                0: day = DAY_MIN + $urandom_range(1000);
                1: day = DAY_MAX - $urandom_range(1000);
                2: day = -100840 + $signed($urandom_range(800)) - 400;
                3: day = -678943 + $signed($urandom_range(3000)) - 1500;
                default: day = longint'($signed(31'($urandom)));
            endcase
            sel = $urandom_range(5);
            case (sel)
                0: secs = longint'($signed({$urandom, $urandom})) >>> 12;
                1: secs = DAY_LEN * ($signed($urandom_range(8)) - 4);
                2: secs = $urandom_range(3) == 0 ? SEC_MIN : SEC_MAX;
                default: secs = longint'($urandom) * 21 + $urandom_range(1);
            endcase
            if ($urandom_range(1)) secs = -secs;
            if (secs > SEC_MAX) secs = SEC_MAX;
            if (secs < SEC_MIN) secs = SEC_MIN;
            send_beat(day, secs, 0, '0);
        end
    endtask

    t_row rows[$];

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_calendar_mode = dmj_pkg::MODE_AUTO;
        i_valid = 1'b0;
        i_day_number = '0;
        i_seconds_offset = '0;
        mode_copy = dmj_pkg::MODE_AUTO;
        errors = 0; beats_in = 0; beats_out = 0; cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0; long_hold = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: epoch, reform edges, negative whole days, extremes.
        rows.push_back('{0, 0, 1, '{23'sd1858, 4'd10, 5'd17, 5'd0, 6'd0, 26'd0}});
        rows.push_back('{-100840, 0, 1, '{23'sd1582, 4'd9, 5'd15, 5'd0, 6'd0, 26'd0}});
        rows.push_back('{-100841, 0, 1, '{23'sd1582, 4'd9, 5'd4, 5'd0, 6'd0, 26'd0}});
        rows.push_back('{1, -DAY_LEN, 1, '{23'sd1858, 4'd10, 5'd17, 5'd0, 6'd0, 26'd0}});
        rows.push_back('{0, DAY_LEN - 1, 1,
                         '{23'sd1858, 4'd10, 5'd17, 5'd23, 6'd59, 26'(MIN_LEN - 1)}});
        rows.push_back('{0, -1, 0, '0});
        rows.push_back('{0, -3 * DAY_LEN, 0, '0});
        rows.push_back('{-678943, 0, 0, '0});
        rows.push_back('{-678942, 0, 0, '0});
        rows.push_back('{51543, 0, 0, '0});
        rows.push_back('{51544 + 365, 0, 0, '0});
        rows.push_back('{51909 - 1, 43200 * (longint'(1) << dmj_pkg::FRAC_BITS), 0, '0});
        rows.push_back('{DAY_MAX, SEC_MAX, 0, '0});
        rows.push_back('{DAY_MIN, SEC_MIN, 0, '0});
        rows.push_back('{DAY_MAX, SEC_MIN, 0, '0});
        rows.push_back('{DAY_MIN, SEC_MAX, 0, '0});
        rows.push_back('{-1, 0, 0, '0});
        for (int k = 0; k < rows.size(); k++)
            send_beat(rows[k].day, rows[k].secs, rows[k].has_date, rows[k].date);
        drain();

        // Every mode, including the code that acts as Julian, at each idling level.
        for (int md = 0; md < 4; md++) begin
            write_mode(2'(md));
            for (int k = 0; k < 5; k++) send_beat(rows[k].day, rows[k].secs, 0, '0);
            send_idle_pct = 0;  recv_stall_pct = 0;  random_beats(40);
            send_idle_pct = 83; recv_stall_pct = 0;  random_beats(35);
            send_idle_pct = 0;  recv_stall_pct = 83; random_beats(35);
            send_idle_pct = 32; recv_stall_pct = 32; random_beats(35);
            drain();
        end

        // Long receiver hold-off while the sender keeps offering beats.
        write_mode(dmj_pkg::MODE_AUTO);
        send_idle_pct = 0; recv_stall_pct = 0;
        long_hold = 1;
        random_beats(40);
        drain();
        long_hold = 0;
        recv_stall_pct = 20;
        random_beats(30);
        drain();

        $display("Covered %0d beats in, %0d results out over all four calendar modes,",
                 beats_in, beats_out);
        $display("with directed extremes, random idling and a long output hold-off.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
